// ----- rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types, sizes and helpers of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int CAP_W       = 4;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AGE_W       = IDX_W;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // depth of the small queues on both sides of the engine
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        logic                         mode;
        logic signed [KEY_BITS-1:0]   lookup_key;
        logic signed [VALUE_BITS-1:0] data_value;
    } t_req;

    typedef struct packed {
        logic                         hit;
        logic signed [VALUE_BITS-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        t_op                          op;
        logic        [KEY_BITS-1:0]   key;
        logic        [VALUE_BITS-1:0] value;
    } t_cmd;

    // capacity write: zero becomes one, too large becomes the entry count
    function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CAP_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > MAX_ENTRIES) begin
            r = CNT_W'(MAX_ENTRIES);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/lkvc_front.sv -----
// ----------------------------------------------------------------------------
// lkvc_front
// Request side: accepts requests, decodes the operation and holds them in a
// short queue for the lookup engine.
// ----------------------------------------------------------------------------
module lkvc_front
    import lkvc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_req i_req,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_take
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_enq;
    logic              w_deq;
    t_cmd              w_cmd;

    assign full        = (r_cnt == QCNT_W'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rptr];
    assign w_enq       = push && !full;
    assign w_deq       = i_cmd_take && o_cmd_valid;

    always_comb begin
        w_cmd.op    = i_req.mode ? OP_PUT : OP_GET;
        w_cmd.key   = i_req.lookup_key;
        w_cmd.value = i_req.data_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_enq) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_deq) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_enq && !w_deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_enq && w_deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/lkvc_back.sv -----
// ----------------------------------------------------------------------------
// lkvc_back
// Lookup engine: entry storage, key compare, recency update, insert and
// eviction. The idle state compares, the execute state updates the entries.
// ----------------------------------------------------------------------------
module lkvc_back
    import lkvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_take,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    input  logic                 i_rsp_full,
    output logic                 o_rsp_push,
    output t_rsp                 o_rsp
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [MAX_ENTRIES-1:0]  r_match;
    logic [MAX_ENTRIES-1:0]  r_valid;
    logic [KEY_BITS-1:0]     r_key   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0]   r_val   [MAX_ENTRIES];
    logic [AGE_W-1:0]        r_age   [MAX_ENTRIES];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_cap;

    logic [MAX_ENTRIES-1:0]  w_match;
    logic                    w_hit;
    logic [IDX_W-1:0]        w_hit_idx;
    logic [AGE_W-1:0]        w_hit_age;
    logic                    w_full;
    logic [MAX_ENTRIES-1:0]  w_evict;
    logic [MAX_ENTRIES-1:0]  w_valid_left;
    logic [IDX_W-1:0]        w_free_idx;
    logic                    w_do;
    logic [MAX_ENTRIES-1:0]  n_valid;
    logic [AGE_W-1:0]        n_age   [MAX_ENTRIES];
    logic [CNT_W-1:0]        n_count;
    logic [MAX_ENTRIES-1:0]  w_key_we;
    logic [MAX_ENTRIES-1:0]  w_val_we;

    // parallel compare against every valid entry
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == i_cmd.key);
        end
    end

    always_comb begin
        w_hit_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_idx = IDX_W'(i);
            end
        end
    end

    assign w_hit     = (r_match != '0);
    assign w_hit_age = r_age[w_hit_idx];
    assign w_full    = (r_count >= r_cap);

    // victim is the valid entry with the oldest rank
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_evict[i] = w_full && r_valid[i] && (r_count != '0)
                         && (r_age[i] == AGE_W'(r_count - 1'b1));
        end
    end

    assign w_valid_left = r_valid & ~w_evict;

    always_comb begin
        w_free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!w_valid_left[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign w_do       = (r_state == S_EXEC) && ((r_cmd.op == OP_PUT) || !i_rsp_full);
    assign o_rsp_push = (r_state == S_EXEC) && (r_cmd.op == OP_GET) && !i_rsp_full;

    always_comb begin
        o_rsp.hit        = w_hit;
        o_rsp.read_value = w_hit ? r_val[w_hit_idx] : '0;
    end

    // next entry state for the update cycle
    always_comb begin
        n_valid  = r_valid;
        n_count  = r_count;
        w_key_we = '0;
        w_val_we = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        if (w_hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_valid[i] && (r_age[i] < w_hit_age)) begin
                    n_age[i] = r_age[i] + 1'b1;
                end
            end
            n_age[w_hit_idx] = '0;
            if (r_cmd.op == OP_PUT) begin
                w_val_we[w_hit_idx] = 1'b1;
            end
        end else if (r_cmd.op == OP_PUT) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (w_valid_left[i]) begin
                    n_age[i] = r_age[i] + 1'b1;
                end
            end
            n_valid              = w_valid_left;
            n_valid[w_free_idx]  = 1'b1;
            n_age[w_free_idx]    = '0;
            w_key_we[w_free_idx] = 1'b1;
            w_val_we[w_free_idx] = 1'b1;
            n_count = (w_evict != '0) ? r_count : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd   <= i_cmd;
            r_match <= w_match;
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_do) begin
                r_age[i] <= n_age[i];
                if (w_key_we[i]) begin
                    r_key[i] <= r_cmd.key;
                end
                if (w_val_we[i]) begin
                    r_val[i] <= r_cmd.value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_cap   <= CNT_W'(MAX_ENTRIES);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_do) begin
                        r_valid <= n_valid;
                        r_count <= n_count;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // capacity is frozen once anything is stored
            if (i_cfg_we && (r_count == '0)) begin
                r_cap <= clamp_capacity(i_cfg_wdata);
            end
        end
    end

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count out of step with valid bits");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(r_match))
        else $error("key stored in more than one entry");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_push |-> !i_rsp_full)
        else $error("result pushed into full queue");

endmodule

// ----- rtl/lkvc_out.sv -----
// ----------------------------------------------------------------------------
// lkvc_out
// Result side: short queue of lookup results presented to the consumer.
// ----------------------------------------------------------------------------
module lkvc_out
    import lkvc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rsp_push,
    input  t_rsp i_rsp,
    output logic o_rsp_full,
    output logic empty,
    input  logic pop,
    output t_rsp o_rsp
);

    t_rsp              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_enq;
    logic              w_deq;

    assign o_rsp_full = (r_cnt == QCNT_W'(QDEPTH));
    assign empty      = (r_cnt == '0);
    assign o_rsp      = r_mem[r_rptr];
    assign w_enq      = i_rsp_push && !o_rsp_full;
    assign w_deq      = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wptr] <= i_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_enq) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_deq) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_enq && !w_deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_enq && w_deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A get request returns one result (hit flag and value, zero on a miss); a put
// request updates or inserts and returns nothing. The lookup engine takes one
// request at a time: its idle state compares the key against all eight
// entries in parallel, its execute state updates values and recency ranks,
// and no new request is taken before that update. Two-deep queues sit on the
// request and result sides; a get waits in the engine while the result queue
// is full. Capacity (1 to 8, reset 8) is taken only while the cache is empty.
module lru_key_value_cache_unit
    import lkvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_req             i_req,
    output logic             empty,
    input  logic             pop,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;
    logic rsp_push;
    t_rsp rsp;
    logic rsp_full;

    lkvc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    lkvc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rsp_full  (rsp_full),
        .o_rsp_push  (rsp_push),
        .o_rsp       (rsp)
    );

    lkvc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rsp_push (rsp_push),
        .i_rsp      (rsp),
        .o_rsp_full (rsp_full),
        .empty      (empty),
        .pop        (pop),
        .o_rsp      (o_rsp)
    );

endmodule
